// ----- hdl/mipsif_pkg.sv -----
// mipsif_pkg: shared types and constants for the mips interface interrupt registers
// no dependencies

package mipsif_pkg;

	// operation codes
	localparam logic [2:0] OP_READ      = 3'd0;
	localparam logic [2:0] OP_WRITE     = 3'd1;
	localparam logic [2:0] OP_RAISE     = 3'd2;
	localparam logic [2:0] OP_CLEAR     = 3'd3;
	localparam logic [2:0] OP_DD_SET    = 3'd4;
	localparam logic [2:0] OP_DD_CLEAR  = 3'd5;

	// register word offsets
	localparam logic [1:0] REG_INIT_MODE = 2'd0;
	localparam logic [1:0] REG_VERSION   = 2'd1;
	localparam logic [1:0] REG_INTR      = 2'd2;
	localparam logic [1:0] REG_MASK      = 2'd3;

	localparam int INIT_W   = 10;
	localparam int SRC_N    = 6;
	localparam int SRC_DP   = 5;

	localparam logic [INIT_W-1:0] INIT_MODE_RST = 10'h080;
	localparam logic [31:0]       VERSION_RST   = 32'h0101_0101;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [1:0]  reg_index;
		logic [31:0] write_data;
		logic [31:0] write_mask;
		logic [5:0]  intr_bits;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        cause_ip2;
		logic        cause_ip3;
	} rsp_t;

endpackage

// ----- hdl/mipsif_core.sv -----
// mipsif_core: architectural registers and per-operation update logic
// depends on mipsif_pkg

module mipsif_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  mipsif_pkg::req_t  req,
	output mipsif_pkg::rsp_t  rsp
);
	import mipsif_pkg::*;

	logic [INIT_W-1:0] init_mode_q, init_mode_d;
	logic [31:0]       version_q, version_d;
	logic [31:0]       pending_q, pending_d;
	logic [SRC_N-1:0]  enable_q, enable_d;
	logic              ip2_q, ip2_d;
	logic              ip3_q, ip3_d;
	logic              eval;
	logic [31:0]       wd;

	assign wd = req.write_data;

	always_comb begin
		init_mode_d = init_mode_q;
		version_d   = version_q;
		pending_d   = pending_q;
		enable_d    = enable_q;
		ip3_d       = ip3_q;
		eval        = 1'b0;
		rsp.read_data = '0;
		unique case (req.opcode)
			OP_READ: begin
				unique case (req.reg_index)
					REG_INIT_MODE: rsp.read_data = {22'd0, init_mode_q};
					REG_VERSION:   rsp.read_data = version_q;
					REG_INTR:      rsp.read_data = pending_q;
					REG_MASK:      rsp.read_data = {26'd0, enable_q};
				endcase
			end
			OP_WRITE: begin
				unique case (req.reg_index)
					REG_INIT_MODE: begin
						// low bits kept, then clear-wins set/clear pairs
						init_mode_d    = wd[INIT_W-1:0];
						init_mode_d[8] = !wd[7] && wd[8];
						init_mode_d[7] = !wd[9] && (wd[10] || wd[7]);
						init_mode_d[9] = !wd[12] && (wd[13] || wd[9]);
						if (wd[11]) begin
							pending_d[SRC_DP] = 1'b0;
							eval = 1'b1;
						end
					end
					REG_MASK: begin
						for (int k = 0; k < SRC_N; k++) begin
							if (wd[2*k])
								enable_d[k] = 1'b0;
							else if (wd[2*k+1])
								enable_d[k] = 1'b1;
						end
						eval = 1'b1;
					end
					REG_VERSION: version_d = (version_q & ~req.write_mask) | wd;
					REG_INTR:    pending_d = (pending_q & ~req.write_mask) | wd;
				endcase
			end
			OP_RAISE: begin
				pending_d = pending_q | {26'd0, req.intr_bits};
				eval = 1'b1;
			end
			OP_CLEAR: begin
				pending_d = pending_q & ~{26'd0, req.intr_bits};
				eval = 1'b1;
			end
			OP_DD_SET:   ip3_d = 1'b1;
			OP_DD_CLEAR: ip3_d = 1'b0;
			default: ;
		endcase
		// pending-and-enabled test on the updated state
		ip2_d = eval ? |(pending_d[SRC_N-1:0] & enable_d) : ip2_q;
		rsp.cause_ip2 = ip2_d;
		rsp.cause_ip3 = ip3_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_mode_q <= INIT_MODE_RST;
			version_q   <= VERSION_RST;
			pending_q   <= '0;
			enable_q    <= '0;
			ip2_q       <= 1'b0;
			ip3_q       <= 1'b0;
		end else if (fire) begin
			init_mode_q <= init_mode_d;
			version_q   <= version_d;
			pending_q   <= pending_d;
			enable_q    <= enable_d;
			ip2_q       <= ip2_d;
			ip3_q       <= ip3_d;
		end
	end

endmodule

// ----- hdl/mips_interface_interrupt_regs_unit.sv -----
// mips_interface_interrupt_regs_unit: top level, request stage, result stage, checks
// depends on mipsif_pkg and mipsif_core

// Interrupt register interface of a console coprocessor: init mode, version,
// interrupt pending and interrupt mask, plus the two processor cause bits
// ip2 (pending and enabled) and ip3 (disk drive line).
// request channel: req_valid / req_ready carry one operation per transfer
//   (read, write, raise, clear, disk drive cause set or clear).
// response channel: rsp_valid / rsp_ready return exactly one result per
//   request, in order: read data (zero for non-reads) and both cause bits
//   as they stand after the operation.
// path: a transferred request waits in the request register, which feeds the
//   update logic; when the request advances, that logic loads the result
//   register and the architectural registers, and rsp_valid is the valid
//   bit of the result register.
// throughput: one request per cycle while responses are taken; the update
//   logic is a single pass with no loop, so nothing limits it further.
// stall: when the receiver holds rsp_ready low, the result register holds,
//   the request register fills, then req_ready drops until a response
//   transfer frees a slot; up to two requests are held in the unit.
// reset: arst_n clears both stages and returns the registers to init mode
//   0x80, version 0x01010101, pending, mask and cause bits zero.

module mips_interface_interrupt_regs_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  mipsif_pkg::req_t  req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output mipsif_pkg::rsp_t  rsp
);
	import mipsif_pkg::*;

	req_t req_s1;
	logic valid_s1;
	rsp_t rsp_s2;
	logic valid_s2;
	rsp_t core_rsp;
	logic adv;

	// request moves into the result stage when that stage is free or draining
	assign adv       = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || adv;

	mipsif_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.req    (req_s1),
		.rsp    (core_rsp)
	);

	// request stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s2 <= core_rsp;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	// a request that advances always shows up as a response next cycle
	a_adv_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> rsp_valid)
		else $error("advanced request produced no response");

	// backpressure only when both stages are full and the output stalls
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (valid_s1 && valid_s2 && !rsp_ready))
		else $error("req_ready low without a full stalled pipeline");

	// a stalled request stage keeps its item until it advances
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(req_s1)))
		else $error("request stage lost or changed a waiting item");

endmodule

// ----- bench/tb_mips_interface_interrupt_regs_unit.sv -----
// tb_mips_interface_interrupt_regs_unit: self-checking bench for the interrupt register unit
// depends on mipsif_pkg and mips_interface_interrupt_regs_unit from hdl

module tb_mips_interface_interrupt_regs_unit;
	import mipsif_pkg::*;

	// opcodes with no defined operation, the unit must leave all state alone
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	localparam int RANDOM_OPS = 1000;
	// stretch of transfers with both sides running flat out
	localparam int CALM_FROM  = 400;
	localparam int CALM_TO    = 650;
	localparam int DRAIN_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// operations still to be offered, and results owed by the unit in order
	req_t ops_to_issue[$];
	rsp_t rsp_awaited[$];

	int issued_count = 0;
	int fail_count = 0;

	// shadow copy of the architectural registers
	logic [31:0] shadow_init;
	logic [31:0] shadow_version;
	logic [31:0] shadow_pending;
	logic [31:0] shadow_enable;
	logic        shadow_ip2;
	logic        shadow_ip3;

	mips_interface_interrupt_regs_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	// clear beats set within one command pair
	function automatic logic [31:0] pair_update(logic [31:0] v, logic clr, logic set,
			logic [31:0] sel);
		if (clr)
			return v & ~sel;
		if (set)
			return v | sel;
		return v;
	endfunction

	function automatic void recheck_ip2();
		shadow_ip2 = ((shadow_pending & shadow_enable) != 32'd0);
	endfunction

	// apply one operation to the shadow registers and return the result it owes
	function automatic rsp_t regs_apply(req_t op);
		rsp_t res;
		logic [31:0] w;
		logic [31:0] r;
		res = '0;
		w = op.write_data;
		case (op.opcode)
			OP_READ: begin
				case (op.reg_index)
					REG_INIT_MODE: res.read_data = shadow_init;
					REG_VERSION:   res.read_data = shadow_version;
					REG_INTR:      res.read_data = shadow_pending;
					default:       res.read_data = shadow_enable;
				endcase
			end
			OP_WRITE: begin
				case (op.reg_index)
					REG_INIT_MODE: begin
						r = w & 32'h3FF;
						r = pair_update(r, w[7], w[8], 32'h100);
						r = pair_update(r, w[9], w[10], 32'h080);
						// command bit 11 drops the dp source and retests
						if (w[11]) begin
							shadow_pending[SRC_DP] = 1'b0;
							recheck_ip2();
						end
						r = pair_update(r, w[12], w[13], 32'h200);
						shadow_init = r;
					end
					REG_MASK: begin
						for (int k = 0; k < SRC_N; k++)
							shadow_enable = pair_update(shadow_enable, w[2*k], w[2*k+1],
								32'd1 << k);
						recheck_ip2();
					end
					// plain merges leave ip2 as it was
					REG_VERSION:
						shadow_version = (shadow_version & ~op.write_mask) | w;
					default:
						shadow_pending = (shadow_pending & ~op.write_mask) | w;
				endcase
			end
			OP_RAISE: begin
				shadow_pending = shadow_pending | {26'd0, op.intr_bits};
				recheck_ip2();
			end
			OP_CLEAR: begin
				shadow_pending = shadow_pending & ~{26'd0, op.intr_bits};
				recheck_ip2();
			end
			OP_DD_SET:   shadow_ip3 = 1'b1;
			OP_DD_CLEAR: shadow_ip3 = 1'b0;
			default: ;
		endcase
		res.cause_ip2 = shadow_ip2;
		res.cause_ip3 = shadow_ip3;
		return res;
	endfunction

	function automatic void queue_op(logic [2:0] opc, logic [1:0] idx, logic [31:0] wd,
			logic [31:0] wm, logic [5:0] ib);
		req_t op;
		op.opcode     = opc;
		op.reg_index  = idx;
		op.write_data = wd;
		op.write_mask = wm;
		op.intr_bits  = ib;
		ops_to_issue.push_back(op);
	endfunction

	// random idle decision, shared by both sides, off during the calm stretch
	function automatic bit skip_cycle();
		if (issued_count >= CALM_FROM && issued_count < CALM_TO)
			return 1'b0;
		return ($urandom_range(99) < 25);
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (fail_count < 100)
			$display("mismatch on %s: got %h, want %h", what, got, want);
		fail_count++;
	endtask

	// request driver: holds an offered op until its transfer, then picks the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			issued_count <= 0;
		end else begin
			if (req_valid && req_ready) begin
				rsp_awaited.push_back(regs_apply(req));
				issued_count <= issued_count + 1;
			end
			// a new op may go out when the slot is empty or just transferred
			if (!req_valid || req_ready) begin
				if (ops_to_issue.size() != 0 && !skip_cycle()) begin
					req <= ops_to_issue.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor: compares each transfer against the oldest owed result
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (rsp_awaited.size() == 0) begin
					flag_mismatch("unexpected response", rsp.read_data, 32'd0);
				end else begin
					want = rsp_awaited.pop_front();
					if (rsp.read_data !== want.read_data)
						flag_mismatch("read_data", rsp.read_data, want.read_data);
					if (rsp.cause_ip2 !== want.cause_ip2)
						flag_mismatch("cause_ip2", {31'd0, rsp.cause_ip2},
							{31'd0, want.cause_ip2});
					if (rsp.cause_ip3 !== want.cause_ip3)
						flag_mismatch("cause_ip3", {31'd0, rsp.cause_ip3},
							{31'd0, want.cause_ip3});
				end
			end
			rsp_ready <= !skip_cycle();
		end
	end

	initial begin
		req_t item;
		int pick;
		shadow_init    = {22'd0, INIT_MODE_RST};
		shadow_version = VERSION_RST;
		shadow_pending = 32'd0;
		shadow_enable  = 32'd0;
		shadow_ip2     = 1'b0;
		shadow_ip3     = 1'b0;

		// reset values of every register
		queue_op(OP_READ, REG_INIT_MODE, 32'd0, 32'd0, 6'd0);
		queue_op(OP_READ, REG_VERSION, 32'd0, 32'd0, 6'd0);
		queue_op(OP_READ, REG_INTR, 32'd0, 32'd0, 6'd0);
		queue_op(OP_READ, REG_MASK, 32'd0, 32'd0, 6'd0);
		// bit-mask merge at both extremes
		queue_op(OP_WRITE, REG_VERSION, 32'hFFFF_FFFF, 32'd0, 6'd0);
		queue_op(OP_WRITE, REG_VERSION, 32'd0, 32'hFFFF_FFFF, 6'd0);
		queue_op(OP_READ, REG_VERSION, 32'd0, 32'd0, 6'd0);
		// plain intr write does not retest ip2, the mask write does
		queue_op(OP_WRITE, REG_INTR, 32'h3F, 32'd0, 6'd0);
		queue_op(OP_WRITE, REG_MASK, 32'hAAA, 32'd0, 6'd0);
		queue_op(OP_WRITE, REG_INTR, 32'd0, 32'hFFFF_FFFF, 6'd0);
		queue_op(OP_READ, REG_INTR, 32'd0, 32'd0, 6'd0);
		// dp raised, then dropped through the init mode command bit
		queue_op(OP_RAISE, REG_INTR, 32'd0, 32'd0, 6'h20);
		queue_op(OP_WRITE, REG_INIT_MODE, 32'h800, 32'd0, 6'd0);
		// every init pair with clear and set together, then sets alone
		queue_op(OP_WRITE, REG_INIT_MODE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
		queue_op(OP_READ, REG_INIT_MODE, 32'd0, 32'd0, 6'd0);
		queue_op(OP_WRITE, REG_INIT_MODE, 32'h2500, 32'd0, 6'd0);
		queue_op(OP_READ, REG_INIT_MODE, 32'd0, 32'd0, 6'd0);
		// mask pairs with clear winning over set
		queue_op(OP_WRITE, REG_MASK, 32'hFFFF_FFFF, 32'd0, 6'd0);
		queue_op(OP_RAISE, REG_VERSION, 32'd0, 32'd0, 6'h3F);
		queue_op(OP_WRITE, REG_MASK, 32'h800, 32'd0, 6'd0);
		queue_op(OP_CLEAR, REG_MASK, 32'd0, 32'd0, 6'h3F);
		// disk drive line and the spare opcodes
		queue_op(OP_DD_SET, REG_INIT_MODE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
		queue_op(OP_SPARE_6, REG_MASK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
		queue_op(OP_DD_CLEAR, REG_INTR, 32'd0, 32'd0, 6'd0);
		queue_op(OP_SPARE_7, REG_INTR, 32'hFFFF_FFFF, 32'd0, 6'h3F);
		queue_op(OP_READ, REG_MASK, 32'd0, 32'd0, 6'd0);

		// random mix, weighted toward writes that actually move enables and sources
		for (int n = 0; n < RANDOM_OPS; n++) begin
			pick = $urandom_range(99);
			if (pick < 22)
				item.opcode = OP_READ;
			else if (pick < 57)
				item.opcode = OP_WRITE;
			else if (pick < 72)
				item.opcode = OP_RAISE;
			else if (pick < 84)
				item.opcode = OP_CLEAR;
			else if (pick < 90)
				item.opcode = OP_DD_SET;
			else if (pick < 96)
				item.opcode = OP_DD_CLEAR;
			else
				item.opcode = ($urandom_range(1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
			item.reg_index  = 2'($urandom_range(3));
			item.write_data = $urandom;
			item.write_mask = $urandom;
			item.intr_bits  = 6'($urandom_range(63));
			pick = $urandom_range(99);
			if (item.opcode == OP_WRITE) begin
				case (item.reg_index)
					REG_MASK: begin
						// often set-only patterns so enables build up
						if (pick < 45)
							item.write_data = item.write_data & 32'hAAA;
						else if (pick < 75)
							item.write_data = item.write_data & 32'hFFF;
					end
					REG_INIT_MODE: begin
						if (pick < 40)
							item.write_data = item.write_data & 32'h3FFF;
					end
					default: begin
						if (pick < 20)
							item.write_mask = 32'd0;
						else if (pick < 40)
							item.write_mask = 32'hFFFF_FFFF;
						else if (pick < 60)
							item.write_data = item.write_data & 32'h3F;
					end
				endcase
			end
			ops_to_issue.push_back(item);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// let every op transfer, then collect what is still owed
		while (ops_to_issue.size() != 0 || req_valid)
			@(negedge clk);
		while (rsp_awaited.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && rsp_awaited.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog well beyond the slowest correct run
	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/mipsif_pkg.sv
hdl/mipsif_core.sv
hdl/mips_interface_interrupt_regs_unit.sv
bench/tb_mips_interface_interrupt_regs_unit.sv
